@@ src/sdc_pkg.sv @@
package sdc_pkg;

    localparam int SERIAL_W = 17;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 6;
    localparam int LEN_W    = 5;
    // running day count, wide enough for the largest serial plus one month
    localparam int COUNT_W  = SERIAL_W + 1;
    // year modulo the 400-year Gregorian cycle
    localparam int YMOD_W   = 9;

    localparam logic [YEAR_W-1:0]  BASE_YEAR  = YEAR_W'(1900);
    localparam logic [YMOD_W-1:0]  BASE_YMOD  = YMOD_W'(300);
    localparam logic [YMOD_W-1:0]  YMOD_LAST  = YMOD_W'(399);
    localparam logic [COUNT_W-1:0] CYCLE_LEN  = COUNT_W'(400);
    localparam logic [YEAR_W-1:0]  YEAR_LAST  = '1;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_MAX    = DAY_W'(31);

    localparam logic [LEN_W-1:0] LEN_COMMON [13] =
        '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
          5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
    localparam logic [LEN_W-1:0] LEN_LEAP [13] =
        '{5'd1, 5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
          5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    // datapath operations selected by the control word
    typedef enum logic [2:0] {
        OP_NOP,
        OP_S_INIT,
        OP_MONTH,
        OP_FIN_DAY,
        OP_SUB400,
        OP_SET_YMOD,
        OP_NORM,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic busy;
        op_t  op;
    } ctrl_t;

    typedef struct packed {
        logic ser_zero;
        logic cnt_ge_ser;
        logic more;
        logic cnt_lt_cycle;
        logic out_full;
    } status_t;

    // leap rule on the year modulo 400
    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        logic leap;
        leap = (ymod[1:0] == 2'b00) && (ymod != YMOD_W'(100))
            && (ymod != YMOD_W'(200)) && (ymod != YMOD_W'(300));
        return leap;
    endfunction

    function automatic logic [LEN_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [LEN_W-1:0] len;
        if (m > MONTH_DEC)
            len = '0;
        else if (leap)
            len = LEN_LEAP[m];
        else
            len = LEN_COMMON[m];
        return len;
    endfunction

endpackage

@@ src/sdc_if.sv @@
interface sdc_in_if import sdc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SERIAL_W-1:0] serial_day;
    logic [YEAR_W-1:0]   year_in;
    logic [MONTH_W-1:0]  month_in;
    logic [DAY_W-1:0]    day_in;

    modport source (output valid, serial_day, year_in, month_in, day_in, input ready);
    modport sink   (input valid, serial_day, year_in, month_in, day_in, output ready);
endinterface

interface sdc_out_if import sdc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               date_valid;
    logic [YEAR_W-1:0]  year_out;
    logic [MONTH_W-1:0] month_out;
    logic [DAY_W-1:0]   day_out;

    modport source (output valid, date_valid, year_out, month_out, day_out, input ready);
    modport sink   (input valid, date_valid, year_out, month_out, day_out, output ready);
endinterface

@@ src/sdc_seq.sv @@
module sdc_seq import sdc_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output ctrl_t   ctrl
);

    localparam int PC_W = 4;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_SER_ZERO,
        COND_CNT_GE_SER,
        COND_MORE,
        COND_CNT_LT_CYCLE,
        COND_END
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    localparam logic [PC_W-1:0] ST_S_WALK = 4'd3;
    localparam logic [PC_W-1:0] ST_S_FIN  = 4'd4;
    localparam logic [PC_W-1:0] ST_D_TEST = 4'd5;
    localparam logic [PC_W-1:0] ST_D_MOD  = 4'd7;
    localparam logic [PC_W-1:0] ST_EMIT   = 4'd9;

    // microprogram
    localparam ucode_t ROM [16] = '{
        '{OP_NOP,      COND_SER_ZERO,     ST_D_TEST},  // dispatch on mode
        '{OP_S_INIT,   COND_NEXT,         '0},         // january 1900
        '{OP_NOP,      COND_CNT_GE_SER,   ST_S_FIN},   // nothing to walk
        '{OP_MONTH,    COND_MORE,         ST_S_WALK},  // one month a cycle
        '{OP_FIN_DAY,  COND_ALWAYS,       ST_EMIT},
        '{OP_NOP,      COND_CNT_LT_CYCLE, ST_D_MOD},   // year mod 400
        '{OP_SUB400,   COND_ALWAYS,       ST_D_TEST},
        '{OP_SET_YMOD, COND_NEXT,         '0},
        '{OP_NORM,     COND_NEXT,         '0},         // day and month roll
        '{OP_EMIT,     COND_END,          '0},
        '{OP_NOP,      COND_END,          '0},
        '{OP_NOP,      COND_END,          '0},
        '{OP_NOP,      COND_END,          '0},
        '{OP_NOP,      COND_END,          '0},
        '{OP_NOP,      COND_END,          '0},
        '{OP_NOP,      COND_END,          '0}
    };

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            busy_reg, busy_next;
    ucode_t          word;
    logic            hold;
    logic            jump;

    always_comb
    begin
        word = ROM[pc_reg];
        hold = (word.op == OP_EMIT) && status.out_full;
        unique case (word.cond)
            COND_NEXT:         jump = 1'b0;
            COND_ALWAYS:       jump = 1'b1;
            COND_SER_ZERO:     jump = status.ser_zero;
            COND_CNT_GE_SER:   jump = status.cnt_ge_ser;
            COND_MORE:         jump = status.more;
            COND_CNT_LT_CYCLE: jump = status.cnt_lt_cycle;
            COND_END:          jump = 1'b0;
            default:           jump = 1'b0;
        endcase

        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            pc_next   = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg && !hold)
        begin
            if (word.cond == COND_END)
            begin
                pc_next   = '0;
                busy_next = 1'b0;
            end
            else if (jump)
                pc_next = word.target;
            else
                pc_next = pc_reg + 1'b1;
        end

        ctrl.busy = busy_reg;
        ctrl.op   = busy_reg ? word.op : OP_NOP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

@@ src/serial_day_to_calendar_date.sv @@
// Converts a spreadsheet serial day to a calendar date, or normalizes a given
// day/month/year when serial_day is 0, and flags whether the result is a valid
// date. One item is worked on at a time by a small microcoded sequencer; the
// input is ready whenever the sequencer is idle, also while a result still
// waits in the output register. Serial mode walks month by month from January
// 1900, one month per cycle. Serials before March 1900 come out one day early,
// and serial 1 yields day 0, month 0, year 1900 (flagged invalid). Direct mode
// first reduces the year modulo 400 by repeated subtraction, with a test state
// and a subtract state per step. A day past the month's end rolls to day 1 of
// the next month and a month past 12 rolls to January of the next year (the
// year wraps at 14 bits). On an invalid result the computed fields are still
// output.
module serial_day_to_calendar_date import sdc_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    sdc_in_if.sink    din,
    sdc_out_if.source dout
);

    ctrl_t   ctrl;
    status_t status;

    // working registers
    logic [SERIAL_W-1:0] serial_reg, serial_next;
    logic [YEAR_W-1:0]   year_reg,   year_next;
    logic [YMOD_W-1:0]   ymod_reg,   ymod_next;
    logic [MONTH_W-1:0]  month_reg,  month_next;
    logic [DAY_W-1:0]    day_reg,    day_next;
    logic [COUNT_W-1:0]  count_reg,  count_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic                date_valid_reg, date_valid_next;
    logic [YEAR_W-1:0]   year_out_reg,  year_out_next;
    logic [MONTH_W-1:0]  month_out_reg, month_out_next;
    logic [DAY_W-1:0]    day_out_reg,   day_out_next;

    logic                accept;
    logic                emit;
    logic                leap;
    logic [LEN_W-1:0]    len_cur;
    logic [COUNT_W-1:0]  serial_ext;
    logic [YEAR_W-1:0]   year_inc;
    logic [YMOD_W-1:0]   ymod_inc;
    // month walk
    logic [MONTH_W-1:0]  walk_month;
    logic [LEN_W-1:0]    walk_len;
    logic [COUNT_W-1:0]  walk_count;
    logic                walk_more;
    // direct-mode roll
    logic                roll_day;
    logic [MONTH_W:0]    roll_month;
    logic                check_ok;

    assign accept = din.valid && din.ready;
    assign emit   = (ctrl.op == OP_EMIT) && !status.out_full;

    sdc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .status (status),
        .ctrl   (ctrl)
    );

    always_comb
    begin
        leap       = is_leap(ymod_reg);
        len_cur    = month_len(leap, month_reg);
        serial_ext = {1'b0, serial_reg};

        // year step, keeping the 400-year phase in line; a 14-bit wrap lands on 0
        year_inc = year_reg + 1'b1;
        if (year_reg == YEAR_LAST || ymod_reg == YMOD_LAST)
            ymod_inc = '0;
        else
            ymod_inc = ymod_reg + 1'b1;

        // one month of the serial walk
        walk_month = (month_reg == MONTH_DEC) ? MONTH_JAN : month_reg + 1'b1;
        walk_len   = month_len(leap, walk_month);
        walk_count = count_reg + COUNT_W'(walk_len);
        walk_more  = walk_count < serial_ext;

        roll_day   = day_reg > DAY_W'(len_cur);
        roll_month = roll_day ? {1'b0, month_reg} + 1'b1 : {1'b0, month_reg};

        check_ok = (day_reg <= DAY_W'(len_cur)) && (day_reg != '0) && (day_reg <= DAY_MAX)
            && (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC);

        status.ser_zero     = (serial_reg == '0);
        status.cnt_ge_ser   = count_reg >= serial_ext;
        status.more         = walk_more;
        status.cnt_lt_cycle = count_reg < CYCLE_LEN;
        status.out_full     = out_valid_reg && !dout.ready;
    end

    // datapath driven by the control word
    always_comb
    begin
        serial_next = serial_reg;
        year_next   = year_reg;
        ymod_next   = ymod_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        count_next  = count_reg;

        if (accept)
        begin
            serial_next = din.serial_day;
            year_next   = din.year_in;
            month_next  = din.month_in;
            day_next    = din.day_in;
            count_next  = COUNT_W'(din.year_in);
        end
        else
        begin
            unique case (ctrl.op)
                OP_NOP, OP_EMIT: ;
                OP_S_INIT:
                begin
                    count_next = COUNT_W'(1);
                    year_next  = BASE_YEAR;
                    ymod_next  = BASE_YMOD;
                    month_next = '0;
                end
                OP_MONTH:
                begin
                    month_next = walk_month;
                    count_next = walk_count;
                    // december closed and still short of the serial: next year
                    if (walk_month == MONTH_DEC && walk_more)
                    begin
                        year_next = year_inc;
                        ymod_next = ymod_inc;
                    end
                end
                OP_FIN_DAY:
                    day_next = DAY_W'(serial_ext - count_reg + COUNT_W'(len_cur));
                OP_SUB400:
                    count_next = count_reg - CYCLE_LEN;
                OP_SET_YMOD:
                    ymod_next = count_reg[YMOD_W-1:0];
                OP_NORM:
                begin
                    if (roll_day)
                        day_next = DAY_W'(1);
                    if (roll_month > (MONTH_W + 1)'(MONTH_DEC))
                    begin
                        month_next = MONTH_JAN;
                        year_next  = year_inc;
                        ymod_next  = ymod_inc;
                    end
                    else
                        month_next = roll_month[MONTH_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        date_valid_next = date_valid_reg;
        year_out_next   = year_out_reg;
        month_out_next  = month_out_reg;
        day_out_next    = day_out_reg;
        out_valid_next  = out_valid_reg;
        if (emit)
        begin
            date_valid_next = check_ok;
            year_out_next   = year_reg;
            month_out_next  = month_reg;
            day_out_next    = day_reg;
            out_valid_next  = 1'b1;
        end
        else if (dout.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        serial_reg     <= serial_next;
        year_reg       <= year_next;
        ymod_reg       <= ymod_next;
        month_reg      <= month_next;
        day_reg        <= day_next;
        count_reg      <= count_next;
        date_valid_reg <= date_valid_next;
        year_out_reg   <= year_out_next;
        month_out_reg  <= month_out_next;
        day_out_reg    <= day_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign din.ready       = !ctrl.busy;
    assign dout.valid      = out_valid_reg;
    assign dout.date_valid = date_valid_reg;
    assign dout.year_out   = year_out_reg;
    assign dout.month_out  = month_out_reg;
    assign dout.day_out    = day_out_reg;

`ifndef SYNTHESIS
    // the walk always leaves a real month behind it
    a_walk_month: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_MONTH |=> (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC))
        else $error("month walk left month out of range");

    // the walk stops only once the serial is reached
    a_walk_stop: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_FIN_DAY |-> count_reg >= serial_ext)
        else $error("month walk stopped short of the serial");

    // the 400-year phase is reduced before any result is formed
    a_ymod_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_EMIT |-> ymod_reg <= YMOD_LAST)
        else $error("year phase out of range at result");

    // a result appears only from the emit step
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dout.valid) |-> $past(ctrl.op == OP_EMIT))
        else $error("result raised outside the emit step");
`endif

endmodule

@@ bench/serial_day_to_calendar_date_tb.sv @@
`timescale 1ns / 1ps

module serial_day_to_calendar_date_tb import sdc_pkg::*;;

    // generous bound: every item at the full serial walk plus long idles, many times over
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int RANDOM_ITEMS = 106;
    // quiet cycles after the last result, to catch anything stray
    localparam int DRAIN_CYCLES = 100;
    localparam int YEAR_TOP     = (1 << YEAR_W) - 1;

    // one input item as the block sees it
    typedef struct packed {
        logic [SERIAL_W-1:0] serial_day;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } date_request_t;

    // one result item
    typedef struct packed {
        logic               ok;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_result_t;

    typedef struct {
        date_request_t req;
        date_result_t  want;
    } date_entry_t;

    // predicts the converted date for each accepted item and checks results in order
    class date_scoreboard;
        localparam int REPORT_LIMIT = 10;

        date_entry_t expected_dates[$];
        int          mismatches;
        int          valid_seen;
        int          invalid_seen;

        function bit leap_year(int unsigned y);
            if (y % 4 != 0)
                return 1'b0;
            if (y % 100 != 0)
                return 1'b1;
            return (y % 400) == 0;
        endfunction

        // entry zero is 0 or 1 depending on leap year, months past 12 have no days
        function int unsigned days_in_month(int unsigned y, int unsigned m);
            int unsigned len;
            case (m)
                0:                     len = leap_year(y) ? 1 : 0;
                2:                     len = leap_year(y) ? 29 : 28;
                4, 6, 9, 11:           len = 30;
                1, 3, 5, 7, 8, 10, 12: len = 31;
                default:               len = 0;
            endcase
            return len;
        endfunction

        function date_result_t convert_date(date_request_t req);
            int unsigned  yr;
            int unsigned  mo;
            int unsigned  dy;
            int unsigned  count;
            int unsigned  serial;
            date_result_t res;
            yr     = 32'(req.year);
            mo     = 32'(req.month);
            dy     = 32'(req.day);
            serial = 32'(req.serial_day);
            if (serial == 0)
            begin
                // direct mode: roll a day past the end, then a month past december
                if (dy > days_in_month(yr, mo))
                begin
                    mo++;
                    dy = 1;
                end
                if (mo > 12)
                begin
                    yr = (yr + 1) % (1 << YEAR_W);
                    mo = 1;
                end
            end
            else
            begin
                // walk months from january 1900, keeping the early one-day offset
                count = 1;
                yr    = 32'(sdc_pkg::BASE_YEAR);
                mo    = 0;
                while (count < serial)
                begin
                    mo    = (mo % 12) + 1;
                    count += days_in_month(yr, mo);
                    if (mo == 12 && count < serial)
                        yr++;
                end
                count -= days_in_month(yr, mo);
                dy    = serial - count;
            end
            res.ok    = (dy <= days_in_month(yr, mo)) && (dy >= 1) && (dy <= 31)
                        && (mo >= 1) && (mo <= 12);
            res.year  = yr[YEAR_W-1:0];
            res.month = mo[MONTH_W-1:0];
            res.day   = dy[DAY_W-1:0];
            return res;
        endfunction

        function void note_input(date_request_t req);
            date_entry_t entry;
            entry.req  = req;
            entry.want = convert_date(req);
            expected_dates.push_back(entry);
        endfunction

        function void check_result(date_result_t got);
            date_entry_t head;
            string       diff;
            if (got.ok)
                valid_seen++;
            else
                invalid_seen++;
            if (expected_dates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with no item pending: ok=%0b %0d-%0d-%0d",
                             $time, got.ok, got.year, got.month, got.day);
                return;
            end
            head = expected_dates.pop_front();
            diff = "";
            if (got.ok !== head.want.ok)
                diff = {diff, " date_valid"};
            if (got.year !== head.want.year)
                diff = {diff, " year_out"};
            if (got.month !== head.want.month)
                diff = {diff, " month_out"};
            if (got.day !== head.want.day)
                diff = {diff, " day_out"};
            if (diff != "")
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $write("%0t: mismatch on%s, serial %0d ymd %0d-%0d-%0d: ",
                           $time, diff, head.req.serial_day, head.req.year,
                           head.req.month, head.req.day);
                    $display("expected ok=%0b %0d-%0d-%0d, got ok=%0b %0d-%0d-%0d",
                             head.want.ok, head.want.year, head.want.month,
                             head.want.day, got.ok, got.year, got.month, got.day);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    sdc_in_if  din();
    sdc_out_if dout();

    date_scoreboard sb = new();

    // no idling on either side while set
    bit steady;
    int serial_items;
    int direct_items;

    serial_day_to_calendar_date u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_cycles();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offers one item, waits for the handshake, then maybe idles
    task automatic send_item(date_request_t req);
        int gap;
        din.valid      <= 1'b1;
        din.serial_day <= req.serial_day;
        din.year_in    <= req.year;
        din.month_in   <= req.month;
        din.day_in     <= req.day;
        do
            @(posedge clk);
        while (din.ready !== 1'b1);
        sb.note_input(req);
        if (req.serial_day == '0)
            direct_items++;
        else
            serial_items++;
        gap = steady ? 0 : idle_cycles();
        if (gap > 0)
        begin
            din.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_serial(int unsigned serial);
        date_request_t req;
        req            = '0;
        req.serial_day = serial[SERIAL_W-1:0];
        send_item(req);
    endtask

    task automatic send_direct(int unsigned yr, int unsigned mo, int unsigned dy);
        date_request_t req;
        req       = '0;
        req.year  = yr[YEAR_W-1:0];
        req.month = mo[MONTH_W-1:0];
        req.day   = dy[DAY_W-1:0];
        send_item(req);
    endtask

    // result side: ready in runs, with random stalls between them
    initial
    begin : result_sink
        int run;
        dout.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            dout.ready <= 1'b1;
            run = $urandom_range(1, 40);
            repeat (run) @(posedge clk);
            run = steady ? 0 : idle_cycles();
            if (run > 0)
            begin
                dout.ready <= 1'b0;
                repeat (run) @(posedge clk);
            end
        end
    end

    // values sampled at the edge are the ones the block handed over
    always @(posedge clk)
    begin : result_monitor
        date_result_t got;
        if (dout.valid === 1'b1 && dout.ready === 1'b1)
        begin
            got.ok    = dout.date_valid;
            got.year  = dout.year_out;
            got.month = dout.month_out;
            got.day   = dout.day_out;
            sb.check_result(got);
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, sb.expected_dates.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        date_request_t req;
        int            pick;
        int unsigned   yr;
        din.valid      <= 1'b0;
        din.serial_day <= '0;
        din.year_in    <= '0;
        din.month_in   <= '0;
        din.day_in     <= '0;
        rst_n          <= 1'b0;
        steady         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // serial 1 lands on day 0 of month 0, invalid
        send_serial(1);
        // early serials one day off, around the end of february 1900
        send_serial(59);
        send_serial(60);
        send_serial(61);
        // year boundary, century years, and the largest serial
        send_serial(366);
        send_serial(36526);
        send_serial(73110);
        send_serial((1 << SERIAL_W) - 1);

        // leap rule: 400-year leap, century common, year 0 leap
        send_direct(2000, 2, 29);
        send_direct(1900, 2, 29);
        send_direct(0, 2, 29);
        // end of the year, and the roll into the next
        send_direct(9998, 12, 31);
        send_direct(9998, 12, 32);
        // year wraps at the top of its width
        send_direct(YEAR_TOP, 12, 32);
        // day extremes
        send_direct(2023, 1, 0);
        send_direct(2023, 1, 63);
        // month zero: kept when the day fits entry zero, else rolls to january
        send_direct(2000, 0, 0);
        send_direct(2000, 0, 1);
        send_direct(2000, 0, 2);
        send_direct(1999, 0, 1);
        // months past december wrap to january of the next year
        send_direct(2024, 13, 5);
        send_direct(2024, 14, 0);
        send_direct(2024, 15, 63);
        send_direct(0, 0, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // a stretch with no idling on either side
            steady = (n >= 60 && n < 80);
            if ($urandom_range(0, 1))
            begin
                // serial mode: mostly short walks, a few near the top
                req.year  = YEAR_W'($urandom);
                req.month = MONTH_W'($urandom);
                req.day   = DAY_W'($urandom);
                pick      = $urandom_range(0, 99);
                if (pick < 25)
                    req.serial_day = SERIAL_W'($urandom_range(1, 400));
                else if (pick < 70)
                    req.serial_day = SERIAL_W'($urandom_range(1, 40000));
                else if (pick < 92)
                    req.serial_day = SERIAL_W'($urandom_range(1, (1 << SERIAL_W) - 1));
                else
                    req.serial_day = SERIAL_W'($urandom_range(125000, (1 << SERIAL_W) - 1));
            end
            else
            begin
                // direct mode: mostly sane dates near month ends, some noise
                req.serial_day = '0;
                pick           = $urandom_range(0, 99);
                if (pick < 30)
                    yr = $urandom_range(0, 99) * 100;
                else if (pick < 40)
                    yr = $urandom_range(0, 2499) * 4;
                else if (pick < 43)
                    yr = YEAR_TOP - $urandom_range(0, 3);
                else
                    yr = $urandom_range(0, 9998);
                req.year = yr[YEAR_W-1:0];
                if ($urandom_range(0, 99) < 80)
                begin
                    req.month = MONTH_W'($urandom_range(1, 12));
                    if ($urandom_range(0, 99) < 60)
                        req.day = DAY_W'($urandom_range(26, 32));
                    else
                        req.day = DAY_W'($urandom_range(1, 31));
                end
                else
                begin
                    req.month = MONTH_W'($urandom_range(0, 15));
                    req.day   = DAY_W'($urandom_range(0, 63));
                end
            end
            send_item(req);
        end
        steady    = 1'b0;
        din.valid <= 1'b0;

        // wait for every expected result, then a quiet stretch
        while (sb.expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d serial-day items and %0d direct-date items",
                 serial_items, direct_items);
        $display("results: %0d valid dates, %0d invalid, %0d mismatches",
                 sb.valid_seen, sb.invalid_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
